/* hdl/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/imghdr_pkg.sv */
package imghdr_pkg;

    typedef logic [1:0] status_t;

    localparam status_t ST_FOUND  = 2'd0;
    localparam status_t ST_BADSEQ = 2'd1;
    localparam status_t ST_ZERO   = 2'd2;
    localparam status_t ST_NOTFND = 2'd3;

    localparam logic [7:0] BYTE_FILL = 8'hFF;
    localparam logic [7:0] BYTE_SOI  = 8'hD8;
    localparam logic [7:0] MARK_SOF0 = 8'hC0;
    localparam logic [7:0] MARK_SOF2 = 8'hC2;

    localparam logic [15:0] SOF_SKIP_LEN = 16'd3;
    localparam logic [15:0] LEN_MIN      = 16'd2;

    localparam logic [4:0] PNG_W_HI    = 5'd18;
    localparam logic [4:0] PNG_W_LO    = 5'd19;
    localparam logic [4:0] PNG_H_HI    = 5'd22;
    localparam logic [4:0] PNG_H_LO    = 5'd23;
    localparam logic [4:0] PNG_POS_MAX = 5'd31;

    typedef struct packed {
        logic        valid;
        logic [15:0] width;
        logic [15:0] height;
        status_t     status;
    } res_t;

endpackage

/* hdl/image_header_dimension_parser_top.sv */
// Image header dimension parser: takes an image file one byte per beat and
// returns one beat with the picture width, height and a status code for each
// file (found, bad marker sequence, zero dimension, or file ended without
// sizes). The format bit, written via cfg_we and cfg_wdata, picks the JPEG
// marker walk (0) or the PNG fixed-offset read (1); write it only while the
// block is idle. start_of_file on a byte restarts the parse with that byte as
// byte 0; after the result of a file, further bytes are dropped until the next
// start mark. The block takes one byte every cycle while not stalled: each
// byte is held in an input register, and the parse core's phase update then
// feeds the result register once the output has room. Input beats
// stall only while a finished result is held at the output and not taken.
module image_header_dimension_parser_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        start_of_file,
    input  logic        end_of_file,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] width,
    output logic [15:0] height,
    output logic [1:0]  status
);

    logic             format_reg;
    logic             hold_valid_reg, hold_valid_next;
    logic [7:0]       hold_byte_reg;
    logic             hold_sof_reg;
    logic             hold_eof_reg;
    logic             room;
    logic             step_en;
    imghdr_pkg::res_t res;

    // Advance the held byte whenever the output stage can take a result.
    assign step_en  = hold_valid_reg && room;
    assign in_ready = !hold_valid_reg || room;

    assign hold_valid_next = (in_valid && in_ready) ? 1'b1 : (step_en ? 1'b0 : hold_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg     <= 1'b0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                format_reg <= cfg_wdata;
            end
            hold_valid_reg <= hold_valid_next;
        end
    end

    // Input register: payload only, captured on each accepted beat.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            hold_byte_reg <= data_byte;
            hold_sof_reg  <= start_of_file;
            hold_eof_reg  <= end_of_file;
        end
    end

    imghdr_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .step_en       (step_en),
        .format_png    (format_reg),
        .data_byte     (hold_byte_reg),
        .start_of_file (hold_sof_reg),
        .end_of_file   (hold_eof_reg),
        .res           (res)
    );

    imghdr_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .width     (width),
        .height    (height),
        .status    (status)
    );

endmodule

/* hdl/imghdr_core.sv */
module imghdr_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step_en,
    input  logic                format_png,
    input  logic [7:0]          data_byte,
    input  logic                start_of_file,
    input  logic                end_of_file,
    output imghdr_pkg::res_t    res
);

    typedef enum logic [3:0] {
        PH_SCAN,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_SKIP,
        PH_CHECK,
        PH_SOF_SKIP,
        PH_H_HI,
        PH_H_LO,
        PH_W_HI,
        PH_W_LO
    } phase_t;

    phase_t      phase_reg, phase_cur, phase_next;
    logic [15:0] skip_reg, skip_cur, skip_next;
    logic [4:0]  pos_reg, pos_cur, pos_next;
    logic [7:0]  hi_reg, hi_cur, hi_next;
    logic [15:0] height_reg, height_cur, height_next;
    logic [15:0] width_reg, width_cur, width_next;
    logic        given_reg, given_cur, given_next;
    logic [15:0] seg_len;
    logic        done;
    imghdr_pkg::status_t st;

    // Start of file clears the walk before the byte is taken as byte 0.
    always_comb
    begin
        phase_cur  = start_of_file ? PH_SCAN : phase_reg;
        skip_cur   = start_of_file ? 16'd0 : skip_reg;
        pos_cur    = start_of_file ? 5'd0 : pos_reg;
        hi_cur     = start_of_file ? 8'd0 : hi_reg;
        height_cur = start_of_file ? 16'd0 : height_reg;
        width_cur  = start_of_file ? 16'd0 : width_reg;
        given_cur  = start_of_file ? 1'b0 : given_reg;
    end

    always_comb
    begin
        phase_next  = phase_cur;
        skip_next   = skip_cur;
        pos_next    = pos_cur;
        hi_next     = hi_cur;
        height_next = height_cur;
        width_next  = width_cur;
        given_next  = given_cur;
        seg_len     = {hi_cur, data_byte};
        done        = 1'b0;
        st          = imghdr_pkg::ST_NOTFND;

        if (!given_cur)
        begin
            if (format_png)
            begin
                priority if (pos_cur == imghdr_pkg::PNG_W_HI)
                begin
                    hi_next = data_byte;
                end
                else if (pos_cur == imghdr_pkg::PNG_W_LO)
                begin
                    width_next = {hi_cur, data_byte};
                end
                else if (pos_cur == imghdr_pkg::PNG_H_HI)
                begin
                    hi_next = data_byte;
                end
                else if (pos_cur == imghdr_pkg::PNG_H_LO)
                begin
                    height_next = {hi_cur, data_byte};
                    done        = 1'b1;
                    st          = (height_next == 16'd0 || width_cur == 16'd0)
                                  ? imghdr_pkg::ST_ZERO : imghdr_pkg::ST_FOUND;
                end
                if (pos_cur < imghdr_pkg::PNG_POS_MAX)
                begin
                    pos_next = pos_cur + 5'd1;
                end
            end
            else
            begin
                unique case (phase_cur)
                    PH_SCAN:
                    begin
                        if (data_byte != imghdr_pkg::BYTE_FILL &&
                            data_byte != imghdr_pkg::BYTE_SOI)
                        begin
                            if (data_byte == imghdr_pkg::MARK_SOF0 ||
                                data_byte == imghdr_pkg::MARK_SOF2)
                            begin
                                skip_next  = imghdr_pkg::SOF_SKIP_LEN;
                                phase_next = PH_SOF_SKIP;
                            end
                            else
                            begin
                                phase_next = PH_LEN_HI;
                            end
                        end
                    end
                    PH_LEN_HI:
                    begin
                        hi_next    = data_byte;
                        phase_next = PH_LEN_LO;
                    end
                    PH_LEN_LO:
                    begin
                        if (seg_len < imghdr_pkg::LEN_MIN)
                        begin
                            done = 1'b1;
                            st   = imghdr_pkg::ST_BADSEQ;
                        end
                        else
                        begin
                            skip_next  = seg_len - imghdr_pkg::LEN_MIN;
                            phase_next = (seg_len == imghdr_pkg::LEN_MIN) ? PH_CHECK : PH_SKIP;
                        end
                    end
                    PH_SKIP:
                    begin
                        skip_next = skip_cur - 16'd1;
                        if (skip_next == 16'd0)
                        begin
                            phase_next = PH_CHECK;
                        end
                    end
                    PH_CHECK:
                    begin
                        if (data_byte != imghdr_pkg::BYTE_FILL)
                        begin
                            done = 1'b1;
                            st   = imghdr_pkg::ST_BADSEQ;
                        end
                        else
                        begin
                            phase_next = PH_SCAN;
                        end
                    end
                    PH_SOF_SKIP:
                    begin
                        skip_next = skip_cur - 16'd1;
                        if (skip_next == 16'd0)
                        begin
                            phase_next = PH_H_HI;
                        end
                    end
                    PH_H_HI:
                    begin
                        hi_next    = data_byte;
                        phase_next = PH_H_LO;
                    end
                    PH_H_LO:
                    begin
                        height_next = {hi_cur, data_byte};
                        phase_next  = PH_W_HI;
                    end
                    PH_W_HI:
                    begin
                        hi_next    = data_byte;
                        phase_next = PH_W_LO;
                    end
                    PH_W_LO:
                    begin
                        width_next = {hi_cur, data_byte};
                        done       = 1'b1;
                        st         = (height_cur == 16'd0 || width_next == 16'd0)
                                     ? imghdr_pkg::ST_ZERO : imghdr_pkg::ST_FOUND;
                    end
                    default:
                    begin
                        phase_next = PH_SCAN;
                    end
                endcase
            end

            if (done || end_of_file)
            begin
                given_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        res.valid  = step_en && !given_cur && (done || end_of_file);
        res.status = done ? st : imghdr_pkg::ST_NOTFND;
        res.width  = (done && st == imghdr_pkg::ST_FOUND) ? width_next : 16'd0;
        res.height = (done && st == imghdr_pkg::ST_FOUND) ? height_next : 16'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SCAN;
            skip_reg   <= 16'd0;
            pos_reg    <= 5'd0;
            hi_reg     <= 8'd0;
            height_reg <= 16'd0;
            width_reg  <= 16'd0;
            given_reg  <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg  <= phase_next;
            skip_reg   <= skip_next;
            pos_reg    <= pos_next;
            hi_reg     <= hi_next;
            height_reg <= height_next;
            width_reg  <= width_next;
            given_reg  <= given_next;
        end
    end

endmodule

/* hdl/imghdr_out_stage.sv */
module imghdr_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  imghdr_pkg::res_t    res,
    output logic                room,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [15:0]         width,
    output logic [15:0]         height,
    output logic [1:0]          status
);

    logic                valid_reg, valid_next;
    logic [15:0]         width_reg, height_reg;
    imghdr_pkg::status_t status_reg;

    // Room for a new beat when empty or when the held beat leaves now.
    assign room       = !valid_reg || out_ready;
    assign valid_next = res.valid ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            width_reg  <= res.width;
            height_reg <= res.height;
            status_reg <= res.status;
        end
    end

    assign out_valid = valid_reg;
    assign width     = width_reg;
    assign height    = height_reg;
    assign status    = status_reg;

endmodule

/* hdl/imghdr_checker.sv */
`include "assert_macros.svh"

module imghdr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] width,
    input logic [15:0] height,
    input logic [1:0]  status
);

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(width) && $stable(height) && $stable(status), "stalled result beat changed")
    `ASSERT_IMPL(a_err_zero, clk, rst_n, out_valid && status != imghdr_pkg::ST_FOUND, width == 16'd0 && height == 16'd0, "error result with nonzero size")
    `ASSERT_IMPL(a_found_size, clk, rst_n, out_valid && status == imghdr_pkg::ST_FOUND, width != 16'd0 && height != 16'd0, "found result with zero size")
    `ASSERT_IMPL(a_ready_empty, clk, rst_n, !out_valid, in_ready, "input stalled with empty output")

endmodule

bind image_header_dimension_parser_top imghdr_checker u_imghdr_checker (.*);

/* bench/image_header_dimension_parser_top_tb.sv */
typedef enum logic [3:0] {
    JP_HUNT,
    JP_LEN_HI,
    JP_LEN_LO,
    JP_SKIP,
    JP_CHECK,
    JP_SOF_SKIP,
    JP_H_HI,
    JP_H_LO,
    JP_W_HI,
    JP_W_LO
} jpeg_phase_t;

typedef struct packed {
    logic [15:0]         w;
    logic [15:0]         h;
    imghdr_pkg::status_t st;
} dims_t;

class header_dimension_tracker;
    localparam int MAX_REPORTS = 10;

    bit          png_mode;
    jpeg_phase_t phase;
    logic [15:0] skip_left;
    logic [4:0]  png_pos;
    logic [7:0]  hi_byte;
    logic [15:0] h_hold;
    logic [15:0] w_hold;
    bit          file_done;
    dims_t       pending_dims[$];
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned results_expected;

    function new();
        png_mode         = 1'b0;
        mismatches       = 0;
        results_seen     = 0;
        results_expected = 0;
        restart();
    endfunction

    function void restart();
        phase     = JP_HUNT;
        skip_left = 16'd0;
        png_pos   = 5'd0;
        hi_byte   = 8'd0;
        h_hold    = 16'd0;
        w_hold    = 16'd0;
        file_done = 1'b0;
    endfunction

    // Advance the parse by one accepted byte; queue the result it gives, if any.
    function void note_byte(logic [7:0] b, logic sof, logic eof);
        logic [15:0]         seg_len;
        bit                  finished;
        imghdr_pkg::status_t st;
        dims_t               res;
        finished = 1'b0;
        st       = imghdr_pkg::ST_NOTFND;
        if (sof)
            restart();
        if (file_done)
            return;
        if (png_mode)
        begin
            if (png_pos == imghdr_pkg::PNG_W_HI || png_pos == imghdr_pkg::PNG_H_HI)
                hi_byte = b;
            else if (png_pos == imghdr_pkg::PNG_W_LO)
                w_hold = {hi_byte, b};
            else if (png_pos == imghdr_pkg::PNG_H_LO)
            begin
                h_hold   = {hi_byte, b};
                finished = 1'b1;
            end
            if (png_pos < imghdr_pkg::PNG_POS_MAX)
                png_pos = png_pos + 5'd1;
        end
        else
        begin
            case (phase)
                JP_HUNT:
                    if (b != imghdr_pkg::BYTE_FILL && b != imghdr_pkg::BYTE_SOI)
                    begin
                        if (b == imghdr_pkg::MARK_SOF0 || b == imghdr_pkg::MARK_SOF2)
                        begin
                            skip_left = imghdr_pkg::SOF_SKIP_LEN;
                            phase     = JP_SOF_SKIP;
                        end
                        else
                            phase = JP_LEN_HI;
                    end
                JP_LEN_HI:
                begin
                    hi_byte = b;
                    phase   = JP_LEN_LO;
                end
                JP_LEN_LO:
                begin
                    seg_len = {hi_byte, b};
                    if (seg_len < imghdr_pkg::LEN_MIN)
                    begin
                        finished = 1'b1;
                        st       = imghdr_pkg::ST_BADSEQ;
                    end
                    else
                    begin
                        skip_left = seg_len - imghdr_pkg::LEN_MIN;
                        if (skip_left == 16'd0)
                            phase = JP_CHECK;
                        else
                            phase = JP_SKIP;
                    end
                end
                JP_SKIP:
                begin
                    skip_left = skip_left - 16'd1;
                    if (skip_left == 16'd0)
                        phase = JP_CHECK;
                end
                JP_CHECK:
                    if (b != imghdr_pkg::BYTE_FILL)
                    begin
                        finished = 1'b1;
                        st       = imghdr_pkg::ST_BADSEQ;
                    end
                    else
                        phase = JP_HUNT;
                JP_SOF_SKIP:
                begin
                    skip_left = skip_left - 16'd1;
                    if (skip_left == 16'd0)
                        phase = JP_H_HI;
                end
                JP_H_HI:
                begin
                    hi_byte = b;
                    phase   = JP_H_LO;
                end
                JP_H_LO:
                begin
                    h_hold = {hi_byte, b};
                    phase  = JP_W_HI;
                end
                JP_W_HI:
                begin
                    hi_byte = b;
                    phase   = JP_W_LO;
                end
                default:
                begin
                    w_hold   = {hi_byte, b};
                    finished = 1'b1;
                end
            endcase
        end
        if (finished && st == imghdr_pkg::ST_NOTFND)
            st = (h_hold == 16'd0 || w_hold == 16'd0) ? imghdr_pkg::ST_ZERO
                                                       : imghdr_pkg::ST_FOUND;
        if (finished || eof)
        begin
            file_done = 1'b1;
            res.st    = st;
            res.w     = (st == imghdr_pkg::ST_FOUND) ? w_hold : 16'd0;
            res.h     = (st == imghdr_pkg::ST_FOUND) ? h_hold : 16'd0;
            pending_dims.push_back(res);
            results_expected++;
        end
    endfunction

    // Compare one result beat with the oldest outstanding expectation.
    function void check_dims(logic [15:0] w, logic [15:0] h, imghdr_pkg::status_t st);
        dims_t want;
        results_seen++;
        if (pending_dims.size() == 0)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("unexpected result: width %0d height %0d status %0d", w, h, st);
            return;
        end
        want = pending_dims.pop_front();
        if (want.w !== w || want.h !== h || want.st !== st)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch: expected width %0d height %0d status %0d, got %0d %0d %0d",
                         want.w, want.h, want.st, w, h, st);
        end
    endfunction
endclass

module image_header_dimension_parser_top_tb;

    localparam int unsigned CYCLE_LIMIT     = 200_000;
    localparam int unsigned DRAIN_CYCLES    = 6;
    localparam int unsigned HOLD_OFF_CYCLES = 400;

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                cfg_we        = 1'b0;
    logic                cfg_wdata     = 1'b0;
    logic                in_valid      = 1'b0;
    logic [7:0]          data_byte     = 8'h00;
    logic                start_of_file = 1'b0;
    logic                end_of_file   = 1'b0;
    logic                out_ready     = 1'b0;
    logic                in_ready;
    logic                out_valid;
    logic [15:0]         width;
    logic [15:0]         height;
    imghdr_pkg::status_t status;

    // Receiver is forced to hold off while this is high.
    logic        hold_on = 1'b0;

    int unsigned send_idle_pct = 14;
    int unsigned recv_idle_pct = 58;
    int unsigned cycle_count   = 0;
    int unsigned bytes_sent    = 0;
    int unsigned files_sent    = 0;

    // Bytes of the file being built, in file order.
    logic [7:0]  file_bytes[$];

    header_dimension_tracker tracker = new();

    image_header_dimension_parser_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .start_of_file (start_of_file),
        .end_of_file   (end_of_file),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .width         (width),
        .height        (height),
        .status        (status)
    );

    always #2 clk = ~clk;

    // Result side: take the beat seen before this edge, then choose whether to
    // accept on the next one. Everything is driven with nonblocking updates,
    // so the values read here are the settled pre-edge ones.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.check_dims(width, height, status);
        if (hold_on)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: stop a hung run.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL image_header_dimension_parser_top");
        $finish;
    end

    function automatic void push_word(logic [15:0] v);
        file_bytes.push_back(v[15:8]);
        file_bytes.push_back(v[7:0]);
    endfunction

    // Append a fill byte, a marker and a length, then length minus two payload bytes.
    function automatic void push_segment(logic [7:0] mark, logic [15:0] seg_len);
        file_bytes.push_back(imghdr_pkg::BYTE_FILL);
        file_bytes.push_back(mark);
        push_word(seg_len);
        for (int i = 2; i < seg_len; i++)
            file_bytes.push_back(8'($urandom));
    endfunction

    // Append a frame header: fill, SOF marker, length and precision (skipped),
    // then height and width.
    function automatic void push_frame_header(logic [7:0] mark, logic [15:0] h,
                                              logic [15:0] w);
        file_bytes.push_back(imghdr_pkg::BYTE_FILL);
        file_bytes.push_back(mark);
        push_word(16'd17);
        file_bytes.push_back(8'd8);
        push_word(h);
        push_word(w);
    endfunction

    // Append n bytes of a PNG-like file with the sizes at their fixed offsets.
    function automatic void push_png(logic [15:0] w, logic [15:0] h, int unsigned n);
        logic [7:0] b;
        for (int i = 0; i < n; i++)
        begin
            b = 8'($urandom);
            if (i == imghdr_pkg::PNG_W_HI)
                b = w[15:8];
            else if (i == imghdr_pkg::PNG_W_LO)
                b = w[7:0];
            else if (i == imghdr_pkg::PNG_H_HI)
                b = h[15:8];
            else if (i == imghdr_pkg::PNG_H_LO)
                b = h[7:0];
            file_bytes.push_back(b);
        end
    endfunction

    // Any marker that is neither a fill, a start of image nor a frame header.
    function automatic logic [7:0] rand_marker();
        logic [7:0] m;
        do
            m = 8'($urandom);
        while (m == imghdr_pkg::BYTE_FILL || m == imghdr_pkg::BYTE_SOI ||
               m == imghdr_pkg::MARK_SOF0 || m == imghdr_pkg::MARK_SOF2);
        return m;
    endfunction

    // Bias sizes towards zero and the extremes.
    function automatic logic [15:0] rand_dim();
        case ($urandom_range(9))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'd1;
            default: return 16'($urandom);
        endcase
    endfunction

    // Build a well-formed file for the current format with random content.
    function automatic void build_good_file();
        file_bytes = {};
        if (tracker.png_mode)
            push_png(rand_dim(), rand_dim(), $urandom_range(24, 32));
        else
        begin
            file_bytes.push_back(imghdr_pkg::BYTE_FILL);
            file_bytes.push_back(imghdr_pkg::BYTE_SOI);
            repeat ($urandom_range(0, 3))
                push_segment(rand_marker(), 16'($urandom_range(2, 9)));
            if ($urandom_range(3) == 0)
                file_bytes.push_back(imghdr_pkg::BYTE_FILL);
            push_frame_header($urandom_range(1) ? imghdr_pkg::MARK_SOF2
                                                : imghdr_pkg::MARK_SOF0,
                              rand_dim(), rand_dim());
            repeat ($urandom_range(0, 3))
                file_bytes.push_back(8'($urandom));
        end
    endfunction

    // Offer one byte and hold it until the block takes it. On return valid is
    // still high; the caller either offers the next byte or drops valid in the
    // same step.
    task automatic send_byte(input logic [7:0] b, input logic sof, input logic eof);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 12)
            gap++;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        data_byte     <= b;
        start_of_file <= sof;
        end_of_file   <= eof;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tracker.note_byte(b, sof, eof);
        bytes_sent++;
    endtask

    task automatic send_file(input logic sof_first, input logic eof_last);
        for (int i = 0; i < file_bytes.size(); i++)
            send_byte(file_bytes[i], sof_first && i == 0,
                      eof_last && i == file_bytes.size() - 1);
        files_sent++;
    endtask

    // Drop valid, wait for every outstanding result, then let the pipeline empty.
    task automatic settle();
        in_valid <= 1'b0;
        while (tracker.pending_dims.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Only call once the block is idle.
    task automatic write_format(input logic png);
        cfg_we    <= 1'b1;
        cfg_wdata <= png;
        @(posedge clk);
        cfg_we           <= 1'b0;
        tracker.png_mode = png;
    endtask

    // Mostly well-formed files; the rest truncated, broken or plain noise.
    task automatic random_file();
        int unsigned kind;
        kind = $urandom_range(99);
        build_good_file();
        if (kind < 70)
            send_file(1'b1, 1'b1);
        else if (kind < 76)
            // no end mark: the next start mark cuts it off
            send_file(1'b1, 1'b0);
        else if (kind < 85)
        begin
            file_bytes = file_bytes[0:$urandom_range(file_bytes.size() - 1)];
            send_file(1'b1, 1'b1);
        end
        else if (kind < 93)
        begin
            if (tracker.png_mode)
                file_bytes[$urandom_range(file_bytes.size() - 1)] = 8'($urandom);
            else
            begin
                // short length, or a segment not followed by a fill byte
                file_bytes = {imghdr_pkg::BYTE_FILL, imghdr_pkg::BYTE_SOI};
                push_segment(rand_marker(), 16'($urandom_range(0, 4)));
                file_bytes.push_back(8'($urandom_range(0, 254)));
                push_frame_header(imghdr_pkg::MARK_SOF0, rand_dim(), rand_dim());
            end
            send_file(1'b1, 1'b1);
        end
        else
            repeat ($urandom_range(4, 30))
                send_byte(8'($urandom), $urandom_range(7) == 0, $urandom_range(7) == 0);
    endtask

    task automatic random_stretch(input int unsigned byte_goal, input int unsigned res_goal);
        int unsigned byte_end;
        int unsigned res_end;
        byte_end = bytes_sent + byte_goal;
        res_end  = tracker.results_expected + res_goal;
        while (bytes_sent < byte_end || tracker.results_expected < res_end)
            random_file();
    endtask

    initial
    begin
        int unsigned leftover;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Straight out of reset: JPEG mode, no start mark on the first byte.
        // The end mark lands after the result and must be ignored.
        file_bytes = {imghdr_pkg::BYTE_FILL, imghdr_pkg::BYTE_SOI};
        push_segment(8'hE0, 16'd4);
        push_frame_header(imghdr_pkg::MARK_SOF0, 16'd1, 16'd1);
        file_bytes.push_back(8'h00);
        send_file(1'b0, 1'b0);
        send_byte(8'h55, 1'b0, 1'b1);
        settle();
        write_format(1'b0);

        // File opens on a frame marker, largest sizes; trailing bytes ignored.
        file_bytes = {};
        push_frame_header(imghdr_pkg::MARK_SOF2, 16'hFFFF, 16'hFFFF);
        void'(file_bytes.pop_front());
        repeat (3) file_bytes.push_back(8'($urandom));
        send_file(1'b1, 1'b1);

        // Opens on another marker; a length of two skips nothing; zero width.
        file_bytes = {};
        push_segment(8'hE1, 16'd2);
        void'(file_bytes.pop_front());
        push_frame_header(imghdr_pkg::MARK_SOF0, 16'h1234, 16'h0000);
        send_file(1'b1, 1'b1);

        // Segment lengths of zero and one.
        file_bytes = {imghdr_pkg::BYTE_FILL, imghdr_pkg::BYTE_SOI};
        push_segment(8'hDB, 16'd0);
        repeat (3) file_bytes.push_back(8'($urandom));
        send_file(1'b1, 1'b1);
        file_bytes = {imghdr_pkg::BYTE_FILL, imghdr_pkg::BYTE_FILL, imghdr_pkg::BYTE_SOI,
                      imghdr_pkg::BYTE_FILL, imghdr_pkg::BYTE_FILL, 8'hC4, 8'h00, 8'h01};
        send_file(1'b1, 1'b1);

        // Segment followed by something other than a fill byte.
        file_bytes = {imghdr_pkg::BYTE_FILL, imghdr_pkg::BYTE_SOI};
        push_segment(8'hE0, 16'd3);
        file_bytes.push_back(8'h00);
        send_file(1'b1, 1'b1);

        // Zero height.
        file_bytes = {imghdr_pkg::BYTE_FILL, imghdr_pkg::BYTE_SOI};
        push_frame_header(imghdr_pkg::MARK_SOF0, 16'd0, 16'd640);
        send_file(1'b1, 1'b1);

        // File ends before any size; then a one-byte file.
        file_bytes = {imghdr_pkg::BYTE_FILL, imghdr_pkg::BYTE_SOI, imghdr_pkg::BYTE_FILL,
                      8'hE0, 8'h00};
        send_file(1'b1, 1'b1);
        file_bytes = {8'h00};
        send_file(1'b1, 1'b1);

        // Restart in the middle of a segment, then a long skip.
        file_bytes = {imghdr_pkg::BYTE_FILL, imghdr_pkg::BYTE_SOI, imghdr_pkg::BYTE_FILL,
                      8'hE0, 8'h00, 8'h10, 8'h12};
        send_file(1'b1, 1'b0);
        file_bytes = {imghdr_pkg::BYTE_FILL, imghdr_pkg::BYTE_SOI};
        push_segment(8'hFE, 16'h0100);
        push_frame_header(imghdr_pkg::MARK_SOF0, 16'd480, 16'd640);
        send_file(1'b1, 1'b1);
        settle();
        write_format(1'b1);

        // PNG: plain, largest, zero width, zero height, cut short.
        file_bytes = {};
        push_png(16'd640, 16'd480, 24);
        send_file(1'b1, 1'b1);
        file_bytes = {};
        push_png(16'hFFFF, 16'hFFFF, 30);
        send_file(1'b1, 1'b1);
        file_bytes = {};
        push_png(16'd0, 16'd5, 26);
        send_file(1'b1, 1'b1);
        file_bytes = {};
        push_png(16'd7, 16'd0, 24);
        send_file(1'b1, 1'b1);
        file_bytes = {};
        push_png(16'd1, 16'd1, 20);
        send_file(1'b1, 1'b1);

        // Switch format in the middle of a file: each walk keeps its own place.
        file_bytes = {};
        push_png(16'd300, 16'd200, 24);
        for (int i = 0; i < 12; i++)
            send_byte(file_bytes[i], i == 0, 1'b0);
        settle();
        write_format(1'b0);
        send_byte(8'hE0, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'h02, 1'b0, 1'b0);
        send_byte(imghdr_pkg::BYTE_FILL, 1'b0, 1'b0);
        settle();
        write_format(1'b1);
        for (int i = 12; i < 24; i++)
            send_byte(file_bytes[i], 1'b0, 1'b0);
        files_sent++;

        // Random traffic: three idling profiles, both formats in each.
        for (int stage = 0; stage < 3; stage++)
        begin
            case (stage)
                0:
                begin
                    send_idle_pct = 14;
                    recv_idle_pct = 58;
                end
                1:
                begin
                    send_idle_pct = 58;
                    recv_idle_pct = 14;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int f = 0; f < 2; f++)
            begin
                settle();
                write_format(f[0] ^ stage[0]);
                random_stretch(30, 2);
                if (stage == 0 && f == 0)
                begin
                    // Hold the result side off while files keep coming, so a
                    // result sits unclaimed and the byte side backs up.
                    fork
                        begin
                            hold_on <= 1'b1;
                            repeat (HOLD_OFF_CYCLES) @(posedge clk);
                            hold_on <= 1'b0;
                        end
                    join_none
                    repeat (3)
                    begin
                        build_good_file();
                        send_file(1'b1, 1'b1);
                    end
                end
            end
        end

        settle();
        leftover = tracker.pending_dims.size();
        if (leftover != 0)
            $display("%0d expected results never arrived", leftover);
        $display("Covered %0d bytes in %0d files, JPEG and PNG, %0d results checked",
                 bytes_sent, files_sent, tracker.results_seen);
        $display("Idling swapped between sides per stage, one long result hold-off, %0d bad",
                 tracker.mismatches);
        if (tracker.mismatches == 0 && leftover == 0)
            $display("PASS image_header_dimension_parser_top");
        else
            $display("FAIL image_header_dimension_parser_top");
        $finish;
    end
endmodule

/* filelist.f */
+incdir+hdl
hdl/imghdr_pkg.sv
hdl/imghdr_core.sv
hdl/imghdr_out_stage.sv
hdl/image_header_dimension_parser_top.sv
hdl/imghdr_checker.sv
bench/image_header_dimension_parser_top_tb.sv
